// ===== sv/rcst_pkg.sv =====
// shared types and constants of the reference counted slot table
// used by the interfaces, the controller, the datapath and the top level
`default_nettype none
package rcst_pkg;

   localparam int REQ_W = 3;
   localparam int SLOT_ID_W = 7;
   localparam int OUT_COUNT_W = 16;
   localparam int STATUS_W = 2;
   localparam int ERR_W = 2;
   localparam int MODE_W = 2;

   localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd0;
   localparam logic [REQ_W-1:0] REQ_ADD = 3'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
   localparam logic [REQ_W-1:0] REQ_DESTROY = 3'd3;
   localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_FREE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUED = 2'd2;

   localparam logic [MODE_W-1:0] MODE_IMMEDIATE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUEUED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DEFERRED = 2'd2;

   localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
   localparam logic [ERR_W-1:0] ERR_TABLE_FULL = 2'd1;
   localparam logic [ERR_W-1:0] ERR_QUEUE_FULL = 2'd2;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_EXEC_RD, S_EXEC,
      S_ALLOC_RD, S_ALLOC_CHK, S_ALLOC_FULL,
      S_ADD_Q, S_ADD_RD, S_ADD_WR,
      S_REM_Q, S_REM_RD, S_REM_WR,
      S_DRN_Q, S_DRN_RD, S_DRN_CHK, S_FINAL
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLR_WR, OP_LATCH, OP_SLOT_RD_REQ, OP_EXEC,
      OP_ALLOC_START, OP_ALLOC_RD, OP_ALLOC_HIT, OP_ALLOC_NEXT, OP_ALLOC_FULL,
      OP_UPD_START, OP_LOG_RD, OP_SLOT_RD_LOG, OP_ADD_APPLY, OP_ADD_DONE,
      OP_REM_APPLY, OP_REM_DONE, OP_DRN_HIT, OP_DRN_SKIP, OP_DRN_DONE, OP_FINAL
   } cmd_op_type;

   typedef enum logic [1:0] {
      LOG_ADD, LOG_REM, LOG_REL
   } log_sel_type;

   typedef struct packed {
      cmd_op_type op;
      log_sel_type log_sel;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic out_free;
      logic [REQ_W-1:0] req_type;
      logic upd_mode;
      logic scan_done;
      logic rd_free;
      logic rd_queued;
      logic add_end;
      logic rem_end;
      logic rel_end;
      logic hold_vld;
   } status_type;

endpackage
`default_nettype wire

// ===== sv/rcst_if.sv =====
// channel interfaces of the slot table: request, result and mode register write
// depends on rcst_pkg for field widths
`default_nettype none
interface rcst_req_if;
   logic valid;
   logic ready;
   logic [rcst_pkg::REQ_W-1:0] req_type;
   logic [rcst_pkg::SLOT_ID_W-1:0] slot_id;
   modport source (output valid, output req_type, output slot_id, input ready);
   modport sink (input valid, input req_type, input slot_id, output ready);
endinterface

interface rcst_rsp_if;
   logic valid;
   logic ready;
   logic [rcst_pkg::SLOT_ID_W-1:0] slot_index;
   logic signed [rcst_pkg::OUT_COUNT_W-1:0] ref_count;
   logic alive;
   logic [rcst_pkg::STATUS_W-1:0] slot_status;
   logic freed;
   logic [rcst_pkg::ERR_W-1:0] error_code;
   logic last;
   modport source (output valid, output slot_index, output ref_count, output alive,
      output slot_status, output freed, output error_code, output last, input ready);
   modport sink (input valid, input slot_index, input ref_count, input alive,
      input slot_status, input freed, input error_code, input last, output ready);
endinterface

interface rcst_csr_if;
   logic valid;
   logic ready;
   logic [rcst_pkg::MODE_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/rcst_ctrl.sv =====
// sequencing state machine of the slot table
// depends on rcst_pkg for state, command and status types
`default_nettype none
module rcst_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire rcst_pkg::status_type sts,
   output rcst_pkg::cmd_type cmd
);

   rcst_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcst_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcst_pkg::S_CLEAR: if (sts.clr_last) state_in = rcst_pkg::S_IDLE;
         rcst_pkg::S_IDLE: if (req_valid) state_in = rcst_pkg::S_DISPATCH;
         rcst_pkg::S_DISPATCH: begin
            case (sts.req_type)
               rcst_pkg::REQ_ALLOC: state_in = rcst_pkg::S_ALLOC_RD;
               rcst_pkg::REQ_ADD, rcst_pkg::REQ_REMOVE, rcst_pkg::REQ_DESTROY:
                  state_in = rcst_pkg::S_EXEC_RD;
               rcst_pkg::REQ_UPDATE:
                  state_in = sts.upd_mode ? rcst_pkg::S_ADD_Q : rcst_pkg::S_FINAL;
               default: state_in = rcst_pkg::S_FINAL;
            endcase
         end
         rcst_pkg::S_EXEC_RD: state_in = rcst_pkg::S_EXEC;
         rcst_pkg::S_EXEC: if (sts.out_free) state_in = rcst_pkg::S_IDLE;
         rcst_pkg::S_ALLOC_RD:
            state_in = sts.scan_done ? rcst_pkg::S_ALLOC_FULL : rcst_pkg::S_ALLOC_CHK;
         rcst_pkg::S_ALLOC_CHK: begin
            if (!sts.rd_free) state_in = rcst_pkg::S_ALLOC_RD;
            else if (sts.out_free) state_in = rcst_pkg::S_IDLE;
         end
         rcst_pkg::S_ALLOC_FULL: if (sts.out_free) state_in = rcst_pkg::S_IDLE;
         rcst_pkg::S_ADD_Q: state_in = sts.add_end ? rcst_pkg::S_REM_Q : rcst_pkg::S_ADD_RD;
         rcst_pkg::S_ADD_RD: state_in = rcst_pkg::S_ADD_WR;
         rcst_pkg::S_ADD_WR: state_in = rcst_pkg::S_ADD_Q;
         rcst_pkg::S_REM_Q: state_in = sts.rem_end ? rcst_pkg::S_DRN_Q : rcst_pkg::S_REM_RD;
         rcst_pkg::S_REM_RD: state_in = rcst_pkg::S_REM_WR;
         rcst_pkg::S_REM_WR: state_in = rcst_pkg::S_REM_Q;
         rcst_pkg::S_DRN_Q: state_in = sts.rel_end ? rcst_pkg::S_FINAL : rcst_pkg::S_DRN_RD;
         rcst_pkg::S_DRN_RD: state_in = rcst_pkg::S_DRN_CHK;
         rcst_pkg::S_DRN_CHK: begin
            if (!sts.rd_queued || !sts.hold_vld || sts.out_free) state_in = rcst_pkg::S_DRN_Q;
         end
         rcst_pkg::S_FINAL: if (sts.out_free) state_in = rcst_pkg::S_IDLE;
         default: state_in = rcst_pkg::S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      req_ready = 1'b0;
      cmd.op = rcst_pkg::OP_NONE;
      cmd.log_sel = rcst_pkg::LOG_ADD;
      case (state_ff)
         rcst_pkg::S_CLEAR: cmd.op = rcst_pkg::OP_CLR_WR;
         rcst_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = rcst_pkg::OP_LATCH;
         end
         rcst_pkg::S_DISPATCH: begin
            if (sts.req_type == rcst_pkg::REQ_ALLOC) cmd.op = rcst_pkg::OP_ALLOC_START;
            else cmd.op = rcst_pkg::OP_UPD_START;
         end
         rcst_pkg::S_EXEC_RD: cmd.op = rcst_pkg::OP_SLOT_RD_REQ;
         rcst_pkg::S_EXEC: if (sts.out_free) cmd.op = rcst_pkg::OP_EXEC;
         rcst_pkg::S_ALLOC_RD: if (!sts.scan_done) cmd.op = rcst_pkg::OP_ALLOC_RD;
         rcst_pkg::S_ALLOC_CHK: begin
            if (!sts.rd_free) cmd.op = rcst_pkg::OP_ALLOC_NEXT;
            else if (sts.out_free) cmd.op = rcst_pkg::OP_ALLOC_HIT;
         end
         rcst_pkg::S_ALLOC_FULL: if (sts.out_free) cmd.op = rcst_pkg::OP_ALLOC_FULL;
         rcst_pkg::S_ADD_Q: cmd.op = sts.add_end ? rcst_pkg::OP_ADD_DONE : rcst_pkg::OP_LOG_RD;
         rcst_pkg::S_ADD_RD: cmd.op = rcst_pkg::OP_SLOT_RD_LOG;
         rcst_pkg::S_ADD_WR: cmd.op = rcst_pkg::OP_ADD_APPLY;
         rcst_pkg::S_REM_Q: begin
            cmd.log_sel = rcst_pkg::LOG_REM;
            cmd.op = sts.rem_end ? rcst_pkg::OP_REM_DONE : rcst_pkg::OP_LOG_RD;
         end
         rcst_pkg::S_REM_RD: begin
            cmd.log_sel = rcst_pkg::LOG_REM;
            cmd.op = rcst_pkg::OP_SLOT_RD_LOG;
         end
         rcst_pkg::S_REM_WR: cmd.op = rcst_pkg::OP_REM_APPLY;
         rcst_pkg::S_DRN_Q: begin
            cmd.log_sel = rcst_pkg::LOG_REL;
            cmd.op = sts.rel_end ? rcst_pkg::OP_DRN_DONE : rcst_pkg::OP_LOG_RD;
         end
         rcst_pkg::S_DRN_RD: begin
            cmd.log_sel = rcst_pkg::LOG_REL;
            cmd.op = rcst_pkg::OP_SLOT_RD_LOG;
         end
         rcst_pkg::S_DRN_CHK: begin
            if (!sts.rd_queued) cmd.op = rcst_pkg::OP_DRN_SKIP;
            else if (!sts.hold_vld || sts.out_free) cmd.op = rcst_pkg::OP_DRN_HIT;
         end
         rcst_pkg::S_FINAL: if (sts.out_free) cmd.op = rcst_pkg::OP_FINAL;
         default: cmd.op = rcst_pkg::OP_NONE;
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/rcst_dpath.sv =====
// slot memory, logs, release queue, counters and result register of the slot table
// depends on rcst_pkg; driven by rcst_ctrl commands
`default_nettype none
module rcst_dpath #(
   parameter int SLOTS = 128,
   parameter int QUEUE_DEPTH = 32,
   parameter int COUNT_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire rcst_pkg::cmd_type cmd,
   output rcst_pkg::status_type sts,
   input  wire logic [rcst_pkg::REQ_W-1:0] req_type,
   input  wire logic [rcst_pkg::SLOT_ID_W-1:0] req_slot_id,
   input  wire logic csr_we,
   input  wire logic [rcst_pkg::MODE_W-1:0] csr_data,
   input  wire logic rsp_ready,
   output logic rsp_valid,
   output logic [rcst_pkg::SLOT_ID_W-1:0] rsp_slot_index,
   output logic signed [rcst_pkg::OUT_COUNT_W-1:0] rsp_ref_count,
   output logic rsp_alive,
   output logic [rcst_pkg::STATUS_W-1:0] rsp_slot_status,
   output logic rsp_freed,
   output logic [rcst_pkg::ERR_W-1:0] rsp_error_code,
   output logic rsp_last
);

   localparam int SB = $clog2(SLOTS);
   localparam int SCW = $clog2(SLOTS + 1);
   localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = COUNT_BITS + 3;
   localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic signed [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
   localparam logic signed [COUNT_BITS-1:0] CNT_NEG = '1;

   // slot entry: count, alive, status
   logic [EW-1:0] slot_mem [SLOTS];
   logic [SB-1:0] add_log [QUEUE_DEPTH];
   logic [SB-1:0] rem_log [QUEUE_DEPTH];
   logic [SB-1:0] rel_q [QUEUE_DEPTH];

   logic [EW-1:0] rd_ff;
   logic [SB-1:0] log_rd_ff;
   logic [rcst_pkg::MODE_W-1:0] mode_ff;
   logic [rcst_pkg::REQ_W-1:0] req_type_ff;
   logic [rcst_pkg::SLOT_ID_W-1:0] slot_id_ff;
   logic [SB-1:0] clr_ff, pos_ff, last_alloc_ff, hold_slot_ff;
   logic [SCW-1:0] scan_ff;
   logic [QCW-1:0] idx_ff, add_cnt_ff, rem_cnt_ff, rel_cnt_ff;
   logic hold_vld_ff;
   logic [rcst_pkg::ERR_W-1:0] upd_err_ff;
   logic rsp_valid_ff;

   logic mem_we, mem_re;
   logic [SB-1:0] mem_wa, mem_ra;
   logic [EW-1:0] mem_wd;
   logic add_push, rem_push, rel_push, log_re;
   logic [SB-1:0] push_slot;
   logic res_load;
   logic [SB-1:0] res_slot;
   logic signed [COUNT_BITS-1:0] res_cnt;
   logic res_alive, res_freed, res_last;
   logic [rcst_pkg::STATUS_W-1:0] res_status;
   logic [rcst_pkg::ERR_W-1:0] res_err;

   logic signed [COUNT_BITS-1:0] rd_cnt;
   logic rd_alive;
   logic [rcst_pkg::STATUS_W-1:0] rd_status;
   logic [SB-1:0] req_slot;
   logic slot_ok, out_free;
   logic [rcst_pkg::MODE_W-1:0] eff_mode;
   logic signed [COUNT_BITS-1:0] cnt_inc, cnt_dec;

   assign rd_cnt = rd_ff[EW-1:3];
   assign rd_alive = rd_ff[2];
   assign rd_status = rd_ff[1:0];
   assign req_slot = SB'(slot_id_ff);
   assign slot_ok = 32'(slot_id_ff) < SLOTS;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign eff_mode = (mode_ff == rcst_pkg::MODE_DEFERRED || mode_ff == rcst_pkg::MODE_QUEUED) ?
                     mode_ff : rcst_pkg::MODE_IMMEDIATE;
   assign cnt_inc = (rd_cnt < CNT_MAX) ? rd_cnt + CNT_ONE : rd_cnt;
   assign cnt_dec = rd_cnt - CNT_ONE;

   always_comb begin
      sts.clr_last = (32'(clr_ff) == SLOTS - 1);
      sts.out_free = out_free;
      sts.req_type = req_type_ff;
      sts.upd_mode = (mode_ff == rcst_pkg::MODE_QUEUED || mode_ff == rcst_pkg::MODE_DEFERRED);
      sts.scan_done = (scan_ff == SCW'(SLOTS));
      sts.rd_free = (rd_status == rcst_pkg::ST_FREE);
      sts.rd_queued = (rd_status == rcst_pkg::ST_QUEUED);
      sts.add_end = (idx_ff == add_cnt_ff);
      sts.rem_end = (idx_ff == rem_cnt_ff);
      sts.rel_end = (idx_ff == rel_cnt_ff);
      sts.hold_vld = hold_vld_ff;
   end

   // command decode
   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_wa = req_slot;
      mem_ra = req_slot;
      mem_wd = {rd_cnt, rd_alive, rd_status};
      add_push = 1'b0;
      rem_push = 1'b0;
      rel_push = 1'b0;
      log_re = 1'b0;
      push_slot = req_slot;
      res_load = 1'b0;
      res_slot = req_slot;
      res_cnt = rd_cnt;
      res_alive = rd_alive;
      res_status = rd_status;
      res_freed = 1'b0;
      res_err = rcst_pkg::ERR_NONE;
      res_last = 1'b1;
      case (cmd.op)
         rcst_pkg::OP_CLR_WR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = {{COUNT_BITS{1'b0}}, 1'b0, rcst_pkg::ST_FREE};
         end
         rcst_pkg::OP_SLOT_RD_REQ: mem_re = 1'b1;
         rcst_pkg::OP_EXEC: begin
            res_load = 1'b1;
            if (!slot_ok) begin
               res_cnt = '0;
               res_alive = 1'b0;
               res_status = rcst_pkg::ST_FREE;
            end else if (req_type_ff == rcst_pkg::REQ_DESTROY) begin
               mem_we = 1'b1;
               mem_wd = {CNT_NEG, 1'b0, rcst_pkg::ST_FREE};
               res_cnt = CNT_NEG;
               res_alive = 1'b0;
               res_status = rcst_pkg::ST_FREE;
               res_freed = 1'b1;
            end else if (eff_mode == rcst_pkg::MODE_DEFERRED) begin
               if (req_type_ff == rcst_pkg::REQ_ADD) begin
                  if (32'(add_cnt_ff) >= QUEUE_DEPTH) res_err = rcst_pkg::ERR_QUEUE_FULL;
                  else add_push = 1'b1;
               end else begin
                  if (32'(rem_cnt_ff) >= QUEUE_DEPTH) res_err = rcst_pkg::ERR_QUEUE_FULL;
                  else rem_push = 1'b1;
               end
            end else if (req_type_ff == rcst_pkg::REQ_ADD) begin
               mem_we = 1'b1;
               mem_wd = {cnt_inc, rd_alive, rd_status};
               res_cnt = cnt_inc;
            end else if (rd_cnt > 0) begin
               if (rd_cnt == CNT_ONE) begin
                  if (eff_mode == rcst_pkg::MODE_IMMEDIATE) begin
                     mem_we = 1'b1;
                     mem_wd = {CNT_NEG, 1'b0, rcst_pkg::ST_FREE};
                     res_cnt = CNT_NEG;
                     res_alive = 1'b0;
                     res_status = rcst_pkg::ST_FREE;
                     res_freed = 1'b1;
                  end else if (32'(rel_cnt_ff) >= QUEUE_DEPTH) begin
                     res_err = rcst_pkg::ERR_QUEUE_FULL;
                  end else begin
                     mem_we = 1'b1;
                     mem_wd = {CNT_NEG, 1'b0, rcst_pkg::ST_QUEUED};
                     rel_push = 1'b1;
                     res_cnt = CNT_NEG;
                     res_alive = 1'b0;
                     res_status = rcst_pkg::ST_QUEUED;
                  end
               end else begin
                  mem_we = 1'b1;
                  mem_wd = {cnt_dec, rd_alive, rd_status};
                  res_cnt = cnt_dec;
               end
            end
         end
         rcst_pkg::OP_ALLOC_RD: begin
            mem_re = 1'b1;
            mem_ra = pos_ff;
         end
         rcst_pkg::OP_ALLOC_HIT: begin
            mem_we = 1'b1;
            mem_wa = pos_ff;
            mem_wd = {CNT_ONE, 1'b1, rcst_pkg::ST_ALLOC};
            res_load = 1'b1;
            res_slot = pos_ff;
            res_cnt = CNT_ONE;
            res_alive = 1'b1;
            res_status = rcst_pkg::ST_ALLOC;
         end
         rcst_pkg::OP_ALLOC_FULL: begin
            res_load = 1'b1;
            res_slot = '0;
            res_cnt = '0;
            res_alive = 1'b0;
            res_status = rcst_pkg::ST_FREE;
            res_err = rcst_pkg::ERR_TABLE_FULL;
         end
         rcst_pkg::OP_LOG_RD: log_re = 1'b1;
         rcst_pkg::OP_SLOT_RD_LOG: begin
            mem_re = 1'b1;
            mem_ra = log_rd_ff;
         end
         rcst_pkg::OP_ADD_APPLY: begin
            mem_we = 1'b1;
            mem_wa = log_rd_ff;
            mem_wd = {cnt_inc, rd_alive, rd_status};
         end
         rcst_pkg::OP_REM_APPLY: begin
            mem_wa = log_rd_ff;
            push_slot = log_rd_ff;
            if (rd_cnt > 0) begin
               if (rd_cnt != CNT_ONE) begin
                  mem_we = 1'b1;
                  mem_wd = {cnt_dec, rd_alive, rd_status};
               end else if (32'(rel_cnt_ff) < QUEUE_DEPTH) begin
                  mem_we = 1'b1;
                  mem_wd = {{COUNT_BITS{1'b0}}, rd_alive, rcst_pkg::ST_QUEUED};
                  rel_push = 1'b1;
               end
            end
         end
         rcst_pkg::OP_DRN_HIT: begin
            mem_we = 1'b1;
            mem_wa = log_rd_ff;
            mem_wd = {CNT_NEG, 1'b0, rcst_pkg::ST_FREE};
            res_load = hold_vld_ff;
            res_slot = hold_slot_ff;
            res_cnt = CNT_NEG;
            res_alive = 1'b0;
            res_status = rcst_pkg::ST_FREE;
            res_freed = 1'b1;
            res_last = 1'b0;
         end
         rcst_pkg::OP_FINAL: begin
            res_load = 1'b1;
            res_slot = hold_vld_ff ? hold_slot_ff : '0;
            res_cnt = hold_vld_ff ? CNT_NEG : '0;
            res_alive = 1'b0;
            res_status = rcst_pkg::ST_FREE;
            res_freed = hold_vld_ff;
            res_err = upd_err_ff;
         end
         default: ;
      endcase
   end

   // slot memory and logs
   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[mem_wa] <= mem_wd;
      if (mem_re) rd_ff <= slot_mem[mem_ra];
      if (add_push) add_log[add_cnt_ff[QIW-1:0]] <= push_slot;
      if (rem_push) rem_log[rem_cnt_ff[QIW-1:0]] <= push_slot;
      if (rel_push) rel_q[rel_cnt_ff[QIW-1:0]] <= push_slot;
      if (log_re) begin
         case (cmd.log_sel)
            rcst_pkg::LOG_ADD: log_rd_ff <= add_log[idx_ff[QIW-1:0]];
            rcst_pkg::LOG_REM: log_rd_ff <= rem_log[idx_ff[QIW-1:0]];
            default: log_rd_ff <= rel_q[idx_ff[QIW-1:0]];
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.op == rcst_pkg::OP_LATCH) begin
         req_type_ff <= req_type;
         slot_id_ff <= req_slot_id;
      end
      if (cmd.op == rcst_pkg::OP_ALLOC_START) begin
         pos_ff <= (32'(last_alloc_ff) == SLOTS - 1) ? '0 : last_alloc_ff + SB'(1);
      end else if (cmd.op == rcst_pkg::OP_ALLOC_NEXT) begin
         pos_ff <= (32'(pos_ff) == SLOTS - 1) ? '0 : pos_ff + SB'(1);
      end
      if (cmd.op == rcst_pkg::OP_DRN_HIT) hold_slot_ff <= log_rd_ff;
      if (res_load) begin
         rsp_slot_index <= rcst_pkg::SLOT_ID_W'(res_slot);
         rsp_ref_count <= rcst_pkg::OUT_COUNT_W'(res_cnt);
         rsp_alive <= res_alive;
         rsp_slot_status <= res_status;
         rsp_freed <= res_freed;
         rsp_error_code <= res_err;
         rsp_last <= res_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rcst_pkg::MODE_IMMEDIATE;
         clr_ff <= '0;
         last_alloc_ff <= '0;
         scan_ff <= '0;
         idx_ff <= '0;
         add_cnt_ff <= '0;
         rem_cnt_ff <= '0;
         rel_cnt_ff <= '0;
         hold_vld_ff <= 1'b0;
         upd_err_ff <= rcst_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) mode_ff <= csr_data;
         if (cmd.op == rcst_pkg::OP_CLR_WR) clr_ff <= clr_ff + SB'(1);
         if (cmd.op == rcst_pkg::OP_ALLOC_HIT) last_alloc_ff <= pos_ff;
         if (cmd.op == rcst_pkg::OP_ALLOC_START) scan_ff <= '0;
         else if (cmd.op == rcst_pkg::OP_ALLOC_NEXT) scan_ff <= scan_ff + SCW'(1);
         if (add_push) add_cnt_ff <= add_cnt_ff + QCW'(1);
         if (rem_push) rem_cnt_ff <= rem_cnt_ff + QCW'(1);
         if (rel_push) rel_cnt_ff <= rel_cnt_ff + QCW'(1);
         case (cmd.op)
            rcst_pkg::OP_UPD_START: begin
               idx_ff <= '0;
               hold_vld_ff <= 1'b0;
               upd_err_ff <= rcst_pkg::ERR_NONE;
            end
            rcst_pkg::OP_ADD_APPLY, rcst_pkg::OP_REM_APPLY, rcst_pkg::OP_DRN_SKIP:
               idx_ff <= idx_ff + QCW'(1);
            rcst_pkg::OP_DRN_HIT: begin
               idx_ff <= idx_ff + QCW'(1);
               hold_vld_ff <= 1'b1;
            end
            rcst_pkg::OP_ADD_DONE: begin
               idx_ff <= '0;
               add_cnt_ff <= '0;
            end
            rcst_pkg::OP_REM_DONE: begin
               idx_ff <= '0;
               rem_cnt_ff <= '0;
            end
            rcst_pkg::OP_DRN_DONE: rel_cnt_ff <= '0;
            rcst_pkg::OP_FINAL: hold_vld_ff <= 1'b0;
            default: ;
         endcase
         if (cmd.op == rcst_pkg::OP_REM_APPLY && rd_cnt == CNT_ONE &&
             32'(rel_cnt_ff) >= QUEUE_DEPTH) begin
            upd_err_ff <= rcst_pkg::ERR_QUEUE_FULL;
         end
         if (res_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== sv/refcount_slot_table.sv =====
// top level of the reference counted slot table
// depends on rcst_pkg, rcst_if, rcst_ctrl and rcst_dpath
//
// usage
//   req_chan carries one request (allocate, add, remove, destroy, update tick)
//   rsp_chan returns its results; every request gives at least one result and
//     the final one has last set; an update tick gives one result per slot freed
//   csr_chan writes release_mode; always ready, write only while idle
// sequencing
//   one request at a time; add, remove and destroy latch the request, read the
//   slot and then execute it and load the result; allocate runs a next-fit search
//   from the slot after the last allocated one, a read and a check per slot probed;
//   an update tick in queued or deferred mode works through the logged adds, the
//   logged removes and the release queue in turn before its final result
// reset
//   synchronous; afterwards a clearing pass over all SLOTS entries zeroes the slot
//   memory, and no request is taken until it ends
// stalls
//   the result register holds a result until rsp ready; the sequencer waits
//   while it is full, so nothing is dropped
`default_nettype none
module refcount_slot_table #(
   parameter int SLOTS = 128,
   parameter int QUEUE_DEPTH = 32,
   parameter int COUNT_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   rcst_req_if.sink req_chan,
   rcst_rsp_if.source rsp_chan,
   rcst_csr_if.sink csr_chan
);

   rcst_pkg::cmd_type cmd;
   rcst_pkg::status_type sts;

   // mode register is always writable
   assign csr_chan.ready = 1'b1;

   rcst_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .sts(sts),
      .cmd(cmd)
   );

   rcst_dpath #(
      .SLOTS(SLOTS),
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .COUNT_BITS(COUNT_BITS)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_type(req_chan.req_type),
      .req_slot_id(req_chan.slot_id),
      .csr_we(csr_chan.valid),
      .csr_data(csr_chan.data),
      .rsp_ready(rsp_chan.ready),
      .rsp_valid(rsp_chan.valid),
      .rsp_slot_index(rsp_chan.slot_index),
      .rsp_ref_count(rsp_chan.ref_count),
      .rsp_alive(rsp_chan.alive),
      .rsp_slot_status(rsp_chan.slot_status),
      .rsp_freed(rsp_chan.freed),
      .rsp_error_code(rsp_chan.error_code),
      .rsp_last(rsp_chan.last)
   );

endmodule
`default_nettype wire
